/* design/uer_pkg.sv */
package uer_pkg;

    // Default configuration of the block.
    localparam int unsigned WIDTH_BITS_DEF = 16;
    localparam int unsigned MID_DEPTH_DEF  = 4;
    localparam int unsigned OUT_DEPTH_DEF  = 8;

    localparam int unsigned TICK_W     = 24;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 24;

    localparam logic [TICK_W-1:0] TICK_MAX = 24'hFF_FFFF;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_TICKS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Q16     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DISTANCE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTANCE  = 3'd4;

    // Register reset values.
    localparam logic [15:0] TRIGGER_TICKS_RST = 16'd80;
    localparam logic [23:0] TIMEOUT_TICKS_RST = 24'd400000;
    localparam logic [15:0] SCALE_Q16_RST     = 16'd1124;
    localparam logic [15:0] MIN_DISTANCE_RST  = 16'd2;
    localparam logic [9:0]  MAX_DISTANCE_RST  = 10'd400;

    // Result status codes.
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_RANGE   = 2'd1;
    localparam logic [1:0] STATUS_TIMEOUT = 2'd2;

    localparam int unsigned ROUND_HALF = 32768;
    localparam logic [9:0]  DIST_CAP   = 10'd999;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TRIG,
        PH_WAIT,
        PH_MEAS
    } phase_t;

    typedef struct packed {
        logic [15:0] trigger_ticks;
        logic [23:0] timeout_ticks;
        logic [15:0] scale_q16;
        logic [15:0] min_distance;
        logic [9:0]  max_distance;
    } cfg_t;

    typedef struct packed {
        logic start_req;
        logic echo_level;
    } in_item_t;

    typedef struct packed {
        logic        trig_level;
        logic        busy_res;
        logic        done_res;
        logic [1:0]  status;
        logic [15:0] pulse_width;
        logic [15:0] range_cm;
        logic [3:0]  digit_hundreds;
        logic [3:0]  digit_tens;
        logic [3:0]  digit_ones;
        logic [1:0]  digit_count;
    } out_item_t;

    // What the front hands to the back for one tick.
    typedef struct packed {
        logic trig;
        logic busy;
        logic done;
        logic timeout;
        logic finish;
    } tick_ctrl_t;

endpackage

/* design/ultrasonic_echo_ranger.sv */
// Ultrasonic echo ranger. Every input beat is one clock tick of the sensor
// pins (start request and synchronized echo level), and every input beat
// yields exactly one result beat, in order. A start request while idle drives
// the trigger for trigger_ticks beats, then the block waits for a fresh
// rising edge of the echo and counts its high time; the falling edge ends the
// measurement with a distance of round(width * scale_q16 / 65536) cm, checked
// against min_distance..max_distance and split into decimal digits, while
// timeout_ticks beats after the trigger without a falling edge end it as a
// timeout. The block takes one beat per clock; full rises only when the
// result side has stopped popping long enough to fill both internal queues.
// Each result beat passes through the queue between the tick sequencer and
// the arithmetic, three pipeline stages (multiply, round and range check,
// digit split), and the result queue, from which it is popped.
// Configuration registers are written through cfg_we, cfg_index and cfg_data
// and should be changed only while no measurement or result is outstanding.
module ultrasonic_echo_ranger #(
    parameter int unsigned WIDTH_BITS = uer_pkg::WIDTH_BITS_DEF,
    parameter int unsigned MID_DEPTH  = uer_pkg::MID_DEPTH_DEF,
    parameter int unsigned OUT_DEPTH  = uer_pkg::OUT_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  uer_pkg::in_item_t                 in_item,
    output logic                              empty,
    input  logic                              pop,
    output uer_pkg::out_item_t                out_item,
    input  logic                              cfg_we,
    input  logic [uer_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int unsigned MID_W     = $bits(uer_pkg::tick_ctrl_t) + WIDTH_BITS;
    localparam int unsigned MID_CNT_W = $clog2(MID_DEPTH + 1);

    uer_pkg::cfg_t          cfg_reg, cfg_next;
    logic                   in_fire;
    uer_pkg::tick_ctrl_t    rec_ctrl, mid_ctrl;
    logic [WIDTH_BITS-1:0]  rec_width, mid_width;
    logic                   mid_pop, mid_empty;
    logic [MID_W-1:0]       mid_rdata;
    logic [MID_CNT_W-1:0]   mid_count;

    assign in_fire = push && !full;

    // Register writes land at once; an index past the list is dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                uer_pkg::REG_TRIGGER_TICKS: cfg_next.trigger_ticks = cfg_data[15:0];
                uer_pkg::REG_TIMEOUT_TICKS: cfg_next.timeout_ticks = cfg_data[23:0];
                uer_pkg::REG_SCALE_Q16:     cfg_next.scale_q16     = cfg_data[15:0];
                uer_pkg::REG_MIN_DISTANCE:  cfg_next.min_distance  = cfg_data[15:0];
                uer_pkg::REG_MAX_DISTANCE:  cfg_next.max_distance  = cfg_data[9:0];
                default:                    cfg_next               = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_ticks <= uer_pkg::TRIGGER_TICKS_RST;
            cfg_reg.timeout_ticks <= uer_pkg::TIMEOUT_TICKS_RST;
            cfg_reg.scale_q16     <= uer_pkg::SCALE_Q16_RST;
            cfg_reg.min_distance  <= uer_pkg::MIN_DISTANCE_RST;
            cfg_reg.max_distance  <= uer_pkg::MAX_DISTANCE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // The front runs the trigger, edge detection and counters one tick per beat.
    uer_front #(
        .WIDTH_BITS (WIDTH_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_item   (in_item),
        .cfg       (cfg_reg),
        .rec_ctrl  (rec_ctrl),
        .rec_width (rec_width)
    );

    // The queue between the two halves; its full flag is the input full.
    uer_fifo #(
        .DATA_W (MID_W),
        .DEPTH  (MID_DEPTH)
    ) u_mid_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (in_fire),
        .pop   (mid_pop),
        .wdata ({rec_ctrl, rec_width}),
        .rdata (mid_rdata),
        .full  (full),
        .empty (mid_empty),
        .count (mid_count)
    );

    assign mid_ctrl  = mid_rdata[MID_W-1:WIDTH_BITS];
    assign mid_width = mid_rdata[WIDTH_BITS-1:0];

    // The back does the distance arithmetic and holds the result queue.
    uer_back #(
        .WIDTH_BITS (WIDTH_BITS),
        .OUT_DEPTH  (OUT_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .mid_empty (mid_empty),
        .mid_ctrl  (mid_ctrl),
        .mid_width (mid_width),
        .mid_pop   (mid_pop),
        .pop       (pop),
        .empty     (empty),
        .out_item  (out_item)
    );

`ifndef SYNTHESIS
    // A finished measurement always returns the block to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_item.done_res) |-> !out_item.busy_res)
        else $error("done beat reports busy");

    // Without done, status and all measurement fields stay zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !out_item.done_res) |->
        (out_item.status == uer_pkg::STATUS_OK && out_item.digit_count == 2'd0 &&
         out_item.pulse_width == 16'd0 && out_item.range_cm == 16'd0))
        else $error("measurement fields set on a beat without done");

    // A timeout carries no width and no distance.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_item.status == uer_pkg::STATUS_TIMEOUT) |->
        (out_item.pulse_width == 16'd0 && out_item.range_cm == 16'd0 &&
         out_item.digit_count == 2'd0))
        else $error("timeout beat carries a measurement");

    // An in-range result has at least one digit and every digit is decimal.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_item.done_res && out_item.status == uer_pkg::STATUS_OK) |->
        (out_item.digit_count != 2'd0 && out_item.digit_hundreds <= 4'd9 &&
         out_item.digit_tens <= 4'd9 && out_item.digit_ones <= 4'd9))
        else $error("bad digit split");

    // The middle queue never holds more beats than it has entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        mid_count <= MID_CNT_W'(MID_DEPTH))
        else $error("middle queue overfilled");
`endif

endmodule

/* design/uer_fifo.sv */
module uer_fifo #(
    parameter int unsigned DATA_W = 8,
    parameter int unsigned DEPTH  = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic                       pop,
    input  logic [DATA_W-1:0]          wdata,
    output logic [DATA_W-1:0]          rdata,
    output logic                       full,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rdata   = mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

/* design/uer_front.sv */
module uer_front #(
    parameter int unsigned WIDTH_BITS = uer_pkg::WIDTH_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_fire,
    input  uer_pkg::in_item_t      in_item,
    input  uer_pkg::cfg_t          cfg,
    output uer_pkg::tick_ctrl_t    rec_ctrl,
    output logic [WIDTH_BITS-1:0]  rec_width
);

    uer_pkg::phase_t                 phase_reg, phase_next;
    logic [uer_pkg::TICK_W-1:0]      tick_reg, tick_next, tick_inc;
    logic [WIDTH_BITS-1:0]           width_reg, width_next;
    logic                            echo_prev_reg;
    logic                            rising;

    assign rising    = in_item.echo_level && !echo_prev_reg;
    assign tick_inc  = (tick_reg == uer_pkg::TICK_MAX) ? tick_reg : tick_reg + 1'b1;
    // A finished measurement reports the width held before this tick.
    assign rec_width = width_reg;

    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        width_next = width_reg;
        rec_ctrl   = '0;
        unique case (phase_reg)
            uer_pkg::PH_IDLE:
            begin
                if (in_item.start_req)
                begin
                    rec_ctrl.trig = 1'b1;
                    width_next    = '0;
                    if (cfg.trigger_ticks <= 16'd1)
                    begin
                        phase_next = uer_pkg::PH_WAIT;
                        tick_next  = '0;
                    end
                    else
                    begin
                        phase_next = uer_pkg::PH_TRIG;
                        tick_next  = uer_pkg::TICK_W'(1);
                    end
                end
            end
            uer_pkg::PH_TRIG:
            begin
                rec_ctrl.trig = 1'b1;
                if (tick_inc >= {8'd0, cfg.trigger_ticks})
                begin
                    phase_next = uer_pkg::PH_WAIT;
                    tick_next  = '0;
                end
                else
                begin
                    tick_next = tick_inc;
                end
            end
            uer_pkg::PH_WAIT, uer_pkg::PH_MEAS:
            begin
                tick_next = tick_inc;
                if (phase_reg == uer_pkg::PH_WAIT)
                begin
                    if (rising)
                    begin
                        phase_next = uer_pkg::PH_MEAS;
                        width_next = WIDTH_BITS'(1);
                    end
                end
                else if (in_item.echo_level)
                begin
                    if (!(&width_reg))
                    begin
                        width_next = width_reg + 1'b1;
                    end
                end
                else
                begin
                    rec_ctrl.finish = 1'b1;
                end
                if (!rec_ctrl.finish && (tick_inc >= cfg.timeout_ticks))
                begin
                    rec_ctrl.timeout = 1'b1;
                end
                if (rec_ctrl.finish || rec_ctrl.timeout)
                begin
                    phase_next = uer_pkg::PH_IDLE;
                end
            end
            default:
            begin
                phase_next = uer_pkg::PH_IDLE;
            end
        endcase
        rec_ctrl.done = rec_ctrl.finish || rec_ctrl.timeout;
        rec_ctrl.busy = (phase_next != uer_pkg::PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= uer_pkg::PH_IDLE;
            tick_reg      <= '0;
            width_reg     <= '0;
            echo_prev_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            phase_reg     <= phase_next;
            tick_reg      <= tick_next;
            width_reg     <= width_next;
            echo_prev_reg <= in_item.echo_level;
        end
    end

endmodule

/* design/uer_back.sv */
module uer_back #(
    parameter int unsigned WIDTH_BITS = uer_pkg::WIDTH_BITS_DEF,
    parameter int unsigned OUT_DEPTH  = uer_pkg::OUT_DEPTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  uer_pkg::cfg_t          cfg,
    input  logic                   mid_empty,
    input  uer_pkg::tick_ctrl_t    mid_ctrl,
    input  logic [WIDTH_BITS-1:0]  mid_width,
    output logic                   mid_pop,
    input  logic                   pop,
    output logic                   empty,
    output uer_pkg::out_item_t     out_item
);

    localparam int unsigned PROD_W = WIDTH_BITS + 16;
    localparam int unsigned SUM_W  = PROD_W + 1;
    localparam int unsigned PW_W   = (WIDTH_BITS > 16) ? WIDTH_BITS : 16;
    localparam int unsigned OCC_W  = $clog2(OUT_DEPTH + 1);

    // Stage A: saturated width and the product width * scale.
    logic                 a_valid_reg;
    uer_pkg::tick_ctrl_t  a_ctrl_reg;
    logic [PROD_W-1:0]    a_prod_reg;
    logic [15:0]          a_pw_reg;
    logic [PW_W-1:0]      w_ext;
    logic [15:0]          pw_sat;

    // Stage B: rounded, saturated distance and range check.
    logic                 b_valid_reg;
    uer_pkg::tick_ctrl_t  b_ctrl_reg;
    logic [15:0]          b_pw_reg;
    logic [15:0]          b_dist_reg;
    logic                 b_ok_reg;
    logic [9:0]           b_cap_reg;
    logic [SUM_W-1:0]     sum, d_wide;
    logic [15:0]          dist_cm;
    logic                 in_range;
    logic [9:0]           capped;

    // Stage C: hundreds digit, remainder and digit count.
    logic                 c_valid_reg;
    uer_pkg::tick_ctrl_t  c_ctrl_reg;
    logic [15:0]          c_pw_reg;
    logic [15:0]          c_dist_reg;
    logic                 c_ok_reg;
    logic [3:0]           c_hund_reg;
    logic [6:0]           c_rem_reg;
    logic [1:0]           c_count_reg;
    logic [15:0]          hund_prod;
    logic [3:0]           hund;
    logic [9:0]           rem_full;
    logic [1:0]           count_digits;

    // Tens and ones, then the result beat.
    logic [14:0]          tens_prod;
    logic [3:0]           tens;
    logic [6:0]           ones_full;
    uer_pkg::out_item_t   res;

    logic [OCC_W-1:0]     out_count;
    logic [OCC_W+1:0]     occupancy;
    logic                 out_full;

    always_comb
    begin
        w_ext  = PW_W'(mid_width);
        pw_sat = ((w_ext >> 16) != '0) ? 16'hFFFF : w_ext[15:0];
    end

    always_comb
    begin
        sum      = SUM_W'(a_prod_reg) + SUM_W'(uer_pkg::ROUND_HALF);
        d_wide   = sum >> 16;
        dist_cm  = ((d_wide >> 16) != '0) ? 16'hFFFF : d_wide[15:0];
        in_range = (dist_cm >= cfg.min_distance) && (dist_cm <= {6'd0, cfg.max_distance});
        capped   = (dist_cm > {6'd0, uer_pkg::DIST_CAP}) ? uer_pkg::DIST_CAP : dist_cm[9:0];
    end

    // n / 100 equals (n * 41) >> 12 for every n below 1000.
    always_comb
    begin
        hund_prod = 16'(b_cap_reg) * 16'd41;
        hund      = hund_prod[15:12];
        rem_full  = b_cap_reg - 10'(hund) * 10'd100;
        if (b_cap_reg >= 10'd100)
        begin
            count_digits = 2'd3;
        end
        else if (b_cap_reg >= 10'd10)
        begin
            count_digits = 2'd2;
        end
        else
        begin
            count_digits = 2'd1;
        end
    end

    // n / 10 equals (n * 205) >> 11 for every n below 100.
    always_comb
    begin
        tens_prod = 15'(c_rem_reg) * 15'd205;
        tens      = tens_prod[14:11];
        ones_full = c_rem_reg - 7'(tens) * 7'd10;
    end

    always_comb
    begin
        res            = '0;
        res.trig_level = c_ctrl_reg.trig;
        res.busy_res   = c_ctrl_reg.busy;
        res.done_res   = c_ctrl_reg.done;
        if (c_ctrl_reg.timeout)
        begin
            res.status = uer_pkg::STATUS_TIMEOUT;
        end
        else if (c_ctrl_reg.finish)
        begin
            res.pulse_width = c_pw_reg;
            res.range_cm    = c_dist_reg;
            if (c_ok_reg)
            begin
                res.status         = uer_pkg::STATUS_OK;
                res.digit_hundreds = c_hund_reg;
                res.digit_tens     = tens;
                res.digit_ones     = ones_full[3:0];
                res.digit_count    = c_count_reg;
            end
            else
            begin
                res.status = uer_pkg::STATUS_RANGE;
            end
        end
    end

    // The pipeline never stalls, so an item leaves the queue only when the
    // output queue has room for it and for everything already in flight.
    // The credit check keeps the output queue from overflowing; the full flag
    // is folded in as a plain guard.
    assign occupancy = (OCC_W+2)'(out_count) + (OCC_W+2)'(a_valid_reg)
                     + (OCC_W+2)'(b_valid_reg) + (OCC_W+2)'(c_valid_reg);
    assign mid_pop   = !mid_empty && !out_full && (occupancy < (OCC_W+2)'(OUT_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= mid_pop;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_ctrl_reg  <= mid_ctrl;
        a_prod_reg  <= PROD_W'(mid_width) * PROD_W'(cfg.scale_q16);
        a_pw_reg    <= pw_sat;
        b_ctrl_reg  <= a_ctrl_reg;
        b_pw_reg    <= a_pw_reg;
        b_dist_reg  <= dist_cm;
        b_ok_reg    <= in_range;
        b_cap_reg   <= capped;
        c_ctrl_reg  <= b_ctrl_reg;
        c_pw_reg    <= b_pw_reg;
        c_dist_reg  <= b_dist_reg;
        c_ok_reg    <= b_ok_reg;
        c_hund_reg  <= hund;
        c_rem_reg   <= rem_full[6:0];
        c_count_reg <= count_digits;
    end

    uer_fifo #(
        .DATA_W ($bits(uer_pkg::out_item_t)),
        .DEPTH  (OUT_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (c_valid_reg),
        .pop   (pop),
        .wdata (res),
        .rdata (out_item),
        .full  (out_full),
        .empty (empty),
        .count (out_count)
    );

endmodule

/* tb/sv/ultrasonic_echo_ranger_checker.sv */
module ultrasonic_echo_ranger_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  logic                           full,
    input  uer_pkg::in_item_t              in_item,
    input  logic                           empty,
    input  logic                           pop,
    input  uer_pkg::out_item_t             out_item,
    input  logic                           cfg_we,
    input  logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_data,
    output int unsigned                    mismatch_count,
    output int unsigned                    readings_pending,
    output uer_pkg::phase_t                ranger_phase,
    output logic                           echo_last
);
    timeunit 1ns;
    timeprecision 1ps;

    import uer_pkg::*;

    localparam int unsigned REPORT_LIMIT = 10;

    cfg_t              regs;
    phase_t            ph;
    logic [TICK_W-1:0] tick_cnt;
    logic [15:0]       width_cnt;
    logic              echo_prev;
    out_item_t         pending_readings[$];
    int unsigned       misses;
    int unsigned       checked;

    // Advances the shadow sensor sequencer by one tick and returns its reading.
    function automatic out_item_t ranging_step(in_item_t beat);
        out_item_t   r;
        logic        rising;
        logic        done;
        logic [32:0] prod;
        logic [16:0] dist_q;
        logic [9:0]  shown;
        r = '0;
        done = 1'b0;
        rising = beat.echo_level && !echo_prev;
        case (ph)
            PH_IDLE:
            begin
                if (beat.start_req)
                begin
                    ph = PH_TRIG;
                    tick_cnt = 24'd1;
                    width_cnt = '0;
                    r.trig_level = 1'b1;
                    if (tick_cnt >= TICK_W'(regs.trigger_ticks))
                    begin
                        ph = PH_WAIT;
                        tick_cnt = '0;
                    end
                end
            end
            PH_TRIG:
            begin
                r.trig_level = 1'b1;
                if (tick_cnt != TICK_MAX)
                    tick_cnt = tick_cnt + 1'b1;
                if (tick_cnt >= TICK_W'(regs.trigger_ticks))
                begin
                    ph = PH_WAIT;
                    tick_cnt = '0;
                end
            end
            default:
            begin
                if (tick_cnt != TICK_MAX)
                    tick_cnt = tick_cnt + 1'b1;
                if (ph == PH_WAIT)
                begin
                    if (rising)
                    begin
                        ph = PH_MEAS;
                        width_cnt = 16'd1;
                    end
                end
                else if (beat.echo_level)
                begin
                    if (width_cnt != '1)
                        width_cnt = width_cnt + 1'b1;
                end
                else
                begin
                    done = 1'b1;
                    prod = 33'(width_cnt) * 33'(regs.scale_q16) + 33'(ROUND_HALF);
                    dist_q = prod[32:16];
                    r.pulse_width = width_cnt;
                    r.range_cm = dist_q[16] ? 16'hFFFF : dist_q[15:0];
                    if (r.range_cm < regs.min_distance ||
                        r.range_cm > 16'(regs.max_distance))
                        r.status = STATUS_RANGE;
                    else
                    begin
                        r.status = STATUS_OK;
                        shown = (r.range_cm > 16'(DIST_CAP)) ? DIST_CAP
                                                             : r.range_cm[9:0];
                        r.digit_hundreds = 4'(shown / 10'd100);
                        r.digit_tens = 4'((shown / 10'd10) % 10'd10);
                        r.digit_ones = 4'(shown % 10'd10);
                        r.digit_count = (shown >= 10'd100) ? 2'd3
                                      : ((shown >= 10'd10) ? 2'd2 : 2'd1);
                    end
                end
                if (!done && tick_cnt >= regs.timeout_ticks)
                begin
                    done = 1'b1;
                    r.status = STATUS_TIMEOUT;
                end
                if (done)
                    ph = PH_IDLE;
            end
        endcase
        echo_prev = beat.echo_level;
        r.busy_res = (ph != PH_IDLE);
        r.done_res = done;
        return r;
    endfunction

    function automatic string differing_fields(out_item_t want, out_item_t got);
        string s;
        s = "";
        if (got.trig_level !== want.trig_level) s = {s, " trig_level"};
        if (got.busy_res !== want.busy_res) s = {s, " busy_res"};
        if (got.done_res !== want.done_res) s = {s, " done_res"};
        if (got.status !== want.status) s = {s, " status"};
        if (got.pulse_width !== want.pulse_width) s = {s, " pulse_width"};
        if (got.range_cm !== want.range_cm) s = {s, " range_cm"};
        if (got.digit_hundreds !== want.digit_hundreds) s = {s, " digit_hundreds"};
        if (got.digit_tens !== want.digit_tens) s = {s, " digit_tens"};
        if (got.digit_ones !== want.digit_ones) s = {s, " digit_ones"};
        if (got.digit_count !== want.digit_count) s = {s, " digit_count"};
        return s;
    endfunction

    function automatic string show(out_item_t v);
        return $sformatf("trig=%0d busy=%0d done=%0d status=%0d width=%0d dist=%0d digits=%0d/%0d/%0d count=%0d",
                         v.trig_level, v.busy_res, v.done_res, v.status, v.pulse_width,
                         v.range_cm, v.digit_hundreds, v.digit_tens, v.digit_ones,
                         v.digit_count);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        out_item_t want;
        string     diffs;
        if (!rst_n)
        begin
            regs.trigger_ticks = TRIGGER_TICKS_RST;
            regs.timeout_ticks = TIMEOUT_TICKS_RST;
            regs.scale_q16 = SCALE_Q16_RST;
            regs.min_distance = MIN_DISTANCE_RST;
            regs.max_distance = MAX_DISTANCE_RST;
            ph = PH_IDLE;
            tick_cnt = '0;
            width_cnt = '0;
            echo_prev = 1'b0;
            pending_readings.delete();
            misses = 0;
            checked = 0;
            mismatch_count <= 0;
            readings_pending <= 0;
            ranger_phase <= PH_IDLE;
            echo_last <= 1'b0;
        end
        else
        begin
            // Results are checked before this edge's input beat is predicted,
            // so a stray result can never match a brand new expectation.
            if (pop && !empty)
            begin
                checked++;
                if (pending_readings.size() == 0)
                begin
                    misses++;
                    if (misses <= REPORT_LIMIT)
                        $display("reading %0d arrived with nothing expected: %s",
                                 checked, show(out_item));
                end
                else
                begin
                    want = pending_readings.pop_front();
                    diffs = differing_fields(want, out_item);
                    if (diffs != "")
                    begin
                        misses++;
                        if (misses <= REPORT_LIMIT)
                        begin
                            $display("reading %0d differs in%s", checked, diffs);
                            $display("    expected %s", show(want));
                            $display("    actual   %s", show(out_item));
                        end
                    end
                end
            end
            if (push && !full)
                pending_readings.push_back(ranging_step(in_item));
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TRIGGER_TICKS: regs.trigger_ticks = cfg_data[15:0];
                    REG_TIMEOUT_TICKS: regs.timeout_ticks = cfg_data[23:0];
                    REG_SCALE_Q16:     regs.scale_q16 = cfg_data[15:0];
                    REG_MIN_DISTANCE:  regs.min_distance = cfg_data[15:0];
                    REG_MAX_DISTANCE:  regs.max_distance = cfg_data[9:0];
                    default:           ;
                endcase
            end
            mismatch_count <= misses;
            readings_pending <= pending_readings.size();
            ranger_phase <= ph;
            echo_last <= echo_prev;
        end
    end

endmodule

/* tb/sv/ultrasonic_echo_ranger_tb.sv */
// Top of the ranger testbench. This module only makes stimulus and gives the
// verdict; the checker beside the block predicts every reading and compares.
module ultrasonic_echo_ranger_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import uer_pkg::*;

    localparam int unsigned HALF_PERIOD    = 6;
    localparam int unsigned RESET_CYCLES   = 7;
    // No legal stretch without an accepted beat comes near this: the longest
    // is the deliberate result hold-off below, plus a long sender gap.
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned HOLD_CYCLES    = 400;
    localparam int unsigned RANDOM_ITEMS   = 350;
    localparam int unsigned RANDOM_PHASES  = 3;
    localparam int unsigned DRAIN_CYCLES   = 16;

    // An index past the register list; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  push;
    logic                  full;
    in_item_t              in_item;
    logic                  empty;
    logic                  pop;
    out_item_t             out_item;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int unsigned mismatch_count;
    int unsigned readings_pending;
    phase_t      ranger_phase;
    logic        echo_last;

    // When set, the sender offers beats back to back with no gaps.
    bit          quiet = 1'b0;
    // Set once the random part starts; the result side then holds off once.
    bit          hold_armed = 1'b0;
    bit          hold_done = 1'b0;
    int unsigned ticks_sent = 0;
    // Trigger length in ticks as the block will see it (zero behaves as one).
    int unsigned trig_len = 32'(TRIGGER_TICKS_RST);

    always #(HALF_PERIOD) clk = ~clk;

    ultrasonic_echo_ranger dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ultrasonic_echo_ranger_checker chk (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .in_item          (in_item),
        .empty            (empty),
        .pop              (pop),
        .out_item         (out_item),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mismatch_count   (mismatch_count),
        .readings_pending (readings_pending),
        .ranger_phase     (ranger_phase),
        .echo_last        (echo_last)
    );

    // Length of an idle stretch: mostly short, now and then somewhat longer,
    // and rarely a long one.
    function automatic int unsigned idle_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic coin();
        return 1'($urandom_range(0, 1));
    endfunction

    // Offers one tick of the sensor pins and returns at the edge that takes it.
    // push is left high, so a following beat can go out at the very next edge.
    task automatic send_tick(input logic start, input logic echo);
        int unsigned gap;
        in_item_t    beat;
        gap = (quiet || coin()) ? 0 : idle_length();
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        beat.start_req = start;
        beat.echo_level = echo;
        push <= 1'b1;
        in_item <= beat;
        @(posedge clk);
        while (full)
            @(posedge clk);
        ticks_sent++;
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [15:0] trig, input logic [23:0] timeout,
                             input logic [15:0] scale, input logic [15:0] near_cm,
                             input logic [9:0] far_cm);
        write_register(REG_TRIGGER_TICKS, 24'(trig));
        write_register(REG_TIMEOUT_TICKS, timeout);
        write_register(REG_SCALE_Q16, 24'(scale));
        write_register(REG_MIN_DISTANCE, 24'(near_cm));
        write_register(REG_MAX_DISTANCE, 24'(far_cm));
        trig_len = (trig == 16'd0) ? 1 : int'(trig);
    endtask

    // Brings the block back to idle and waits for every outstanding reading.
    // Each beat is sent alone, with push low in between, so the checker's view
    // of the sequencer already includes the previous beat when the next echo
    // level is chosen: a low-high-low pattern closes any open measurement.
    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (ranger_phase != PH_IDLE)
        begin
            send_tick(1'b0, (ranger_phase == PH_WAIT) ? !echo_last : 1'b0);
            push <= 1'b0;
            @(posedge clk);
        end
        while (readings_pending != 0)
            @(posedge clk);
    endtask

    // One measurement: the start beat, the rest of the trigger, a low lead-in
    // of the echo, a pulse of the given width and the falling edge. With noise
    // on, start requests are sprinkled over the busy ticks (they must be
    // ignored) and the echo wanders during the trigger, which sometimes leaves
    // it high when waiting begins.
    task automatic ping(input int unsigned lead, input int unsigned high,
                        input bit noisy);
        send_tick(1'b1, noisy ? coin() : 1'b0);
        repeat (trig_len - 1) send_tick(noisy ? coin() : 1'b0, noisy ? coin() : 1'b0);
        repeat (lead) send_tick(noisy ? coin() : 1'b0, 1'b0);
        repeat (high) send_tick(noisy ? coin() : 1'b0, 1'b1);
        send_tick(noisy ? coin() : 1'b0, 1'b0);
    endtask

    // Result side: pops in runs, stalls in gaps of random length, and once,
    // early in the random part, holds off long enough that both internal
    // queues fill and full is raised while the sender keeps offering beats.
    initial
    begin
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_armed && !hold_done)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else if ($urandom_range(0, 99) < 60)
            begin
                pop <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
            else
            begin
                pop <= 1'b0;
                repeat (idle_length()) @(posedge clk);
            end
        end
    end

    // Watchdog: any cycle that moves a beat on either side restarts the count.
    initial
    begin : watchdog
        int unsigned stuck_cycles;
        stuck_cycles = 0;
        wait (rst_n === 1'b1);
        while (stuck_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned phase_goal;
        int unsigned pick;
        rst_n <= 1'b0;
        push <= 1'b0;
        in_item <= '0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Registers at their reset values: a distance just at the near limit,
        // then a noisy run with starts while busy whose short pulse lands
        // below it.
        ping(2, 100, 1'b0);
        ping(3, 40, 1'b1);
        settle();

        // A zero trigger length behaves as one tick, and a zero timeout ends
        // the attempt on the first tick after the trigger, even when the echo
        // rises on that very tick.
        configure(16'd0, 24'd0, 16'd0, 16'd0, 10'd0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
        settle();

        // Timeout of ten ticks with a zero scale, so every finished distance
        // is zero and in range.
        configure(16'd1, 24'd10, 16'd0, 16'd0, 10'd0);
        // The falling edge lands on the tenth tick and wins over the timeout.
        ping(3, 6, 1'b0);
        // One tick later the timeout comes first.
        ping(3, 7, 1'b0);
        // The echo is already high when waiting begins: that is no edge, so
        // the block waits for a low and a fresh rise, then measures two ticks.
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        // No echo at all: the wait runs out.
        send_tick(1'b1, 1'b0);
        repeat (10) send_tick(1'b0, 1'b0);
        settle();

        // With the far limit above 999, an in-range distance over 999 shows
        // as three nines; a one-tick pulse gives a single digit.
        quiet = 1'b1;
        configure(16'd1, 24'hFF_FFFF, 16'hFFFF, 16'd0, 10'd1023);
        ping(0, 1000, 1'b0);
        ping(2, 1, 1'b0);
        quiet = 1'b0;
        settle();

        // Roughly one centimeter per tick: one and two digits, the top of the
        // range, and one past it.
        configure(16'd3, 24'd5000, 16'hFFFF, 16'd0, 10'd42);
        ping(1, 7, 1'b0);
        ping(1, 42, 1'b0);
        ping(1, 43, 1'b0);
        settle();

        // The near limit at its maximum puts everything out of range. A write
        // to an index past the list must leave the registers alone.
        configure(16'd2, 24'd300, 16'h8000, 16'hFFFF, 10'd999);
        ping(0, 9, 1'b1);
        settle();
        write_register(REG_UNMAPPED, 24'hFF_FFFF);
        ping(0, 20, 1'b0);
        settle();

        // Random part: each phase picks its own settings, then mostly sends
        // complete measurements with random timing and noise, mixed with short
        // bursts of arbitrary pin levels. One phase runs with no sender gaps.
        hold_armed = 1'b1;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            configure(16'($urandom_range(0, 6)),
                      ($urandom_range(0, 3) == 0) ? 24'($urandom_range(0, 40))
                                                  : 24'($urandom_range(60, 3000)),
                      16'($urandom_range(0, 65535)),
                      ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535))
                                                  : 16'($urandom_range(0, 30)),
                      10'($urandom_range(0, 1023)));
            quiet = (p == 2);
            phase_goal = ticks_sent + RANDOM_ITEMS / RANDOM_PHASES;
            while (ticks_sent < phase_goal)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 80)
                    ping(($urandom_range(0, 3) == 0) ? $urandom_range(0, 40)
                                                     : $urandom_range(0, 4),
                         ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200)
                                                     : $urandom_range(1, 24),
                         $urandom_range(0, 3) != 0);
                else
                    repeat ($urandom_range(1, 8)) send_tick(coin(), coin());
            end
            quiet = 1'b0;
            settle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && readings_pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* filelist.f */
design/uer_pkg.sv
design/uer_fifo.sv
design/uer_front.sv
design/uer_back.sv
design/ultrasonic_echo_ranger.sv
tb/sv/ultrasonic_echo_ranger_checker.sv
tb/sv/ultrasonic_echo_ranger_tb.sv
